### design/ptts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Command codes, report limits and the structures passed between the
// controller and the chain of slot cells.
// ----------------------------------------------------------------------------
package ptts_pkg;

   // Command codes carried in the kind field.
   localparam logic [2:0] KIND_TICK    = 3'd0;
   localparam logic [2:0] KIND_CREATE  = 3'd1;
   localparam logic [2:0] KIND_SUSPEND = 3'd2;
   localparam logic [2:0] KIND_RESUME  = 3'd3;
   localparam logic [2:0] KIND_DELETE  = 3'd4;

   // Status codes reported with every result.
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OCCUPIED = 1'b1;

   // At most this many firings are reported for one tick.
   localparam logic [3:0] MAX_REPORTS = 4'd8;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic        create;
      logic        suspend;
      logic        resume;
      logic        remove;
      logic [2:0]  slot;
      logic [15:0] period;
      logic [15:0] first_delay;
      logic        shift;   // move the walk token one cell along
      logic        step;    // the cell holding the token applies the tick
   } cmd_type;

   // Returned from each cell to the controller.
   typedef struct packed {
      logic fire;           // token here and the slot fires on this step
      logic hit_present;    // addressed by the command and present
   } cell_stat_type;

endpackage

### design/ptts_cell.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler slot cell
// Holds one task slot and one stage of the walk token that is handed from
// cell to cell during a tick.
// ----------------------------------------------------------------------------
module ptts_cell
   import ptts_pkg::*;
#(
   parameter int SLOT_INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic          tok_prev,
   output logic          tok_out,
   output cell_stat_type stat
);

   logic        present_ff, present_in;
   logic        running_ff, running_in;
   logic [15:0] countdown_ff, countdown_in;
   logic [15:0] period_ff, period_in;
   logic        tok_ff, tok_in;
   logic        sel;
   logic        cd_zero;

   assign sel     = (int'(cmd.slot) == SLOT_INDEX);
   assign cd_zero = (countdown_ff == 16'd0);

   // Next state from commands and from the tick step while holding the token.
   always_comb begin
      present_in   = present_ff;
      running_in   = running_ff;
      countdown_in = countdown_ff;
      period_in    = period_ff;
      tok_in       = cmd.shift ? tok_prev : tok_ff;
      if (sel && cmd.create && !present_ff) begin
         present_in   = 1'b1;
         running_in   = 1'b1;
         period_in    = cmd.period;
         countdown_in = cmd.first_delay;
      end
      if (sel && cmd.suspend) begin
         running_in = 1'b0;
      end
      if (sel && cmd.resume) begin
         running_in = 1'b1;
      end
      if (sel && cmd.remove) begin
         present_in = 1'b0;
      end
      if (tok_ff && cmd.step && running_ff) begin
         if (!cd_zero) begin
            countdown_in = countdown_ff - 16'd1;
         end else if (present_ff) begin
            countdown_in = period_ff - 16'd1;
         end
      end
   end

   // Slot marks, countdown and token.
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= 1'b0;
         running_ff   <= 1'b0;
         countdown_ff <= 16'd0;
         tok_ff       <= 1'b0;
      end else begin
         present_ff   <= present_in;
         running_ff   <= running_in;
         countdown_ff <= countdown_in;
         tok_ff       <= tok_in;
      end
   end

   // Reload period is only read once create has written it.
   always_ff @(posedge clock) begin
      period_ff <= period_in;
   end

   assign tok_out          = tok_ff;
   assign stat.fire        = tok_ff && running_ff && cd_zero && present_ff;
   assign stat.hit_present = sel && present_ff;

endmodule

### design/periodic_task_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler core
// Task slots indexed by priority, kept in a chain of cells. A tick walks a token
// down the chain, one slot per cycle unless paused, and reports each firing task.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  kind, slot, period, first_delay
//   rsp      out        rsp_valid / rsp_stall  status, fired, fired_slot, last
//
// Create, suspend, resume and delete complete in the cycle they are accepted.
// A tick is accepted, then the token passes down the chain one slot cell at
// a time, and the final result is sent from the flush state.
// Reset is synchronous and clears every slot at once; no clearing pass.
// The walk pauses while a held firing waits for a stalled result register;
// a new transaction is taken only when idle with the result register free.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_core
   import ptts_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_period,
   input  logic [15:0] req_first_delay,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic        rsp_fired,
   output logic [2:0]  rsp_fired_slot,
   output logic        rsp_last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [3:0]       rep_cnt_ff;
   logic             pend_valid_ff;
   logic [2:0]       pend_slot_ff;
   logic             rsp_valid_ff;
   logic             rsp_status_ff;
   logic             rsp_fired_ff;
   logic [2:0]       rsp_fired_slot_ff;
   logic             rsp_last_ff;

   cmd_type          cmd;
   cell_stat_type    stat [SLOTS];
   logic [SLOTS-1:0] tok_vec;
   logic [SLOTS-1:0] fire_vec;
   logic [SLOTS-1:0] hit_vec;
   logic [IDX_W+2:0] idx_ext;
   logic             out_free;
   logic             req_take;
   logic             is_tick;
   logic             start;
   logic             walk_adv;
   logic             report;
   logic             at_end;
   logic             rsp_load;

   // Handshake and walk control.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_take  = req_valid && !req_stall;
   assign is_tick   = (req_kind == KIND_TICK);
   assign start     = req_take && is_tick;
   assign walk_adv  = (state_ff == ST_WALK) && (!pend_valid_ff || out_free);
   assign report    = (|fire_vec) && (rep_cnt_ff < MAX_REPORTS);
   assign at_end    = (idx_ff == IDX_W'(SLOTS - 1));
   assign idx_ext   = {3'b000, idx_ff};

   // A result is loaded when a command completes, when a held firing is
   // passed on, or when a tick closes.
   assign rsp_load = ((state_ff == ST_IDLE) && req_take && !is_tick) ||
                     ((state_ff == ST_WALK) && walk_adv && report && pend_valid_ff) ||
                     ((state_ff == ST_FLUSH) && out_free);

   // Command broadcast to the chain.
   always_comb begin
      cmd.create      = req_take && (req_kind == KIND_CREATE);
      cmd.suspend     = req_take && (req_kind == KIND_SUSPEND);
      cmd.resume      = req_take && (req_kind == KIND_RESUME);
      cmd.remove      = req_take && (req_kind == KIND_DELETE);
      cmd.slot        = req_slot;
      cmd.period      = req_period;
      cmd.first_delay = req_first_delay;
      cmd.shift       = start || walk_adv;
      cmd.step        = walk_adv;
   end

   // Chain of slot cells; the token enters at slot zero.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic tok_prev;
      if (i == 0) begin : g_head
         assign tok_prev = start;
      end else begin : g_link
         assign tok_prev = tok_vec[i-1];
      end
      ptts_cell #(
         .SLOT_INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .tok_prev (tok_prev),
         .tok_out  (tok_vec[i]),
         .stat     (stat[i])
      );
      assign fire_vec[i] = stat[i].fire;
      assign hit_vec[i]  = stat[i].hit_present;
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         rep_cnt_ff    <= 4'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  if (is_tick) begin
                     state_ff      <= ST_WALK;
                     idx_ff        <= '0;
                     rep_cnt_ff    <= 4'd0;
                     pend_valid_ff <= 1'b0;
                  end else begin
                     rsp_status_ff     <= (cmd.create && (|hit_vec)) ?
                                          STATUS_OCCUPIED : STATUS_OK;
                     rsp_fired_ff      <= 1'b0;
                     rsp_fired_slot_ff <= 3'd0;
                     rsp_last_ff       <= 1'b1;
                  end
               end
            end
            ST_WALK: begin
               if (walk_adv) begin
                  if (report) begin
                     // The held firing is not the last one: send it now.
                     if (pend_valid_ff) begin
                        rsp_status_ff     <= STATUS_OK;
                        rsp_fired_ff      <= 1'b1;
                        rsp_fired_slot_ff <= pend_slot_ff;
                        rsp_last_ff       <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_slot_ff  <= idx_ext[2:0];
                     rep_cnt_ff    <= rep_cnt_ff + 4'd1;
                  end
                  if (at_end) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     idx_ff <= idx_ff + IDX_W'(1);
                  end
               end
            end
            ST_FLUSH: begin
               // Final result: the held firing, or an empty one.
               if (out_free) begin
                  rsp_status_ff     <= STATUS_OK;
                  rsp_fired_ff      <= pend_valid_ff;
                  rsp_fired_slot_ff <= pend_valid_ff ? pend_slot_ff : 3'd0;
                  rsp_last_ff       <= 1'b1;
                  pend_valid_ff     <= 1'b0;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_fired_slot = rsp_fired_slot_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef ASSERT_OFF
   // At most one cell holds the walk token.
   a_token_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("walk token held by more than one cell");

   // During a walk the token sits in the cell named by the slot counter.
   a_token_at_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> tok_vec[idx_ff])
      else $error("walk token out of step with slot counter");

   // Reported firings never exceed the limit.
   a_report_limit: assert property (@(posedge clock) disable iff (reset)
      rep_cnt_ff <= MAX_REPORTS)
      else $error("too many firings reported");

   // A result not marked last is always followed by more of the same tick.
   a_nonlast_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff != ST_IDLE))
      else $error("unterminated result sequence while idle");
`endif

endmodule
